>>> sv/aat_pkg.sv
`default_nettype none
package aat_pkg;

  localparam int COORD_W    = 32;
  localparam int COEF_W     = 16;
  localparam int COEF_FRAC  = 12;
  localparam int NUM_AXES   = 3;
  localparam int ROW_W      = NUM_AXES * COEF_W;
  localparam int BOX_W      = 2 * NUM_AXES * COORD_W;
  localparam int PROD_W     = COORD_W + COEF_W;
  localparam int TERM_W     = PROD_W - COEF_FRAC;
  localparam int SUM_W      = TERM_W + 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = ROW_W;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [TERM_W-1:0]  term_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_X = 3'd0,
    CFG_ROW_Y = 3'd1,
    CFG_ROW_Z = 3'd2,
    CFG_OFF_X = 3'd3,
    CFG_OFF_Y = 3'd4,
    CFG_OFF_Z = 3'd5
  } cfg_idx_e;

  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC;

  // add a scaled term and clamp to the coordinate range
  function automatic coord_t sat_add(input coord_t a, input term_t b);
    logic signed [SUM_W-1:0] s;
    logic [SUM_W-COORD_W:0]  top;
    coord_t                  r;
    s   = SUM_W'(a) + SUM_W'(b);
    top = s[SUM_W-1:COORD_W-1];
    if ((&top) || !(|top)) begin
      r = s[COORD_W-1:0];
    end else if (s[SUM_W-1]) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> sv/aabb_affine_transform_top.sv
`default_nettype none
// Maps one axis-aligned box per beat through a 3x3 Q4.12 matrix plus a Q16.16 translation and
// returns the tight box around the image, each axis sum clamped to signed 32 bits after every
// term. A box is accepted in every cycle unless a stall fills the pipeline; a result is
// offered once the box has passed the input register, a product register of eighteen 16x32
// multipliers and the clamped-sum register. Master-side stalls hold only the full stages.
// The user must write configuration only while idle; the block itself does not enforce it.
module aabb_affine_transform_top (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_we_i,
  input  wire [aat_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire [aat_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  wire                             s_axis_tvalid,
  output logic                            s_axis_tready,
  // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z
  input  wire [aat_pkg::BOX_W-1:0]        s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  wire                             m_axis_tready,
  // new_lo_x, new_lo_y, new_lo_z, new_hi_x, new_hi_y, new_hi_z
  output logic [aat_pkg::BOX_W-1:0]       m_axis_tdata
);
  import aat_pkg::*;

  logic [ROW_W-1:0] coef_q [NUM_AXES];
  coord_t           off_q  [NUM_AXES];

  logic             v1_q, v2_q, v3_q;
  logic             en1, en2, en3;
  logic [BOX_W-1:0] in_q;
  term_t            tlo_d [NUM_AXES][NUM_AXES];
  term_t            thi_d [NUM_AXES][NUM_AXES];
  term_t            tlo_q [NUM_AXES][NUM_AXES];
  term_t            thi_q [NUM_AXES][NUM_AXES];
  logic [BOX_W-1:0] out_d, out_q;

  assign en3 = !v3_q || m_axis_tready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready = en1;
  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_AXES; r++) begin
        coef_q[r] <= ROW_W'(COEF_ONE) << (r * COEF_W);
        off_q[r]  <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ROW_X: coef_q[0] <= cfg_wdata_i;
        CFG_ROW_Y: coef_q[1] <= cfg_wdata_i;
        CFG_ROW_Z: coef_q[2] <= cfg_wdata_i;
        CFG_OFF_X: off_q[0]  <= cfg_wdata_i[COORD_W-1:0];
        CFG_OFF_Y: off_q[1]  <= cfg_wdata_i[COORD_W-1:0];
        CFG_OFF_Z: off_q[2]  <= cfg_wdata_i[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // products, min/max swapped where the coefficient is not positive
  always_comb begin
    coef_t                     c;
    coord_t                    lo, hi, a, b;
    logic signed [PROD_W-1:0]  pa, pb;
    for (int r = 0; r < NUM_AXES; r++) begin
      for (int j = 0; j < NUM_AXES; j++) begin
        c  = coef_q[r][j*COEF_W +: COEF_W];
        lo = in_q[j*COORD_W +: COORD_W];
        hi = in_q[(j+NUM_AXES)*COORD_W +: COORD_W];
        a  = (c > 0) ? lo : hi;
        b  = (c > 0) ? hi : lo;
        pa = PROD_W'(c) * PROD_W'(a);
        pb = PROD_W'(c) * PROD_W'(b);
        tlo_d[r][j] = pa[PROD_W-1:COEF_FRAC];
        thi_d[r][j] = pb[PROD_W-1:COEF_FRAC];
      end
    end
  end

  always_comb begin
    coord_t acc_lo, acc_hi;
    out_d = '0;
    for (int r = 0; r < NUM_AXES; r++) begin
      acc_lo = off_q[r];
      acc_hi = off_q[r];
      for (int j = 0; j < NUM_AXES; j++) begin
        acc_lo = sat_add(acc_lo, tlo_q[r][j]);
        acc_hi = sat_add(acc_hi, thi_q[r][j]);
      end
      out_d[r*COORD_W +: COORD_W]            = acc_lo;
      out_d[(r+NUM_AXES)*COORD_W +: COORD_W] = acc_hi;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && s_axis_tvalid) in_q <= s_axis_tdata;
    if (en2 && v1_q) begin
      tlo_q <= tlo_d;
      thi_q <= thi_d;
    end
    if (en3 && v2_q) out_q <= out_d;
  end

endmodule
`default_nettype wire

>>> sv/aat_checker.sv
`default_nettype none
module aat_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          s_axis_tvalid,
  input wire                          s_axis_tready,
  input wire                          m_axis_tvalid,
  input wire                          m_axis_tready,
  input wire [aat_pkg::BOX_W-1:0]     m_axis_tdata
);

  // result beat held until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result data changed while stalled");

  // pipeline only back-pressures when the output stage is full and stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input stalled with free output stage");

  // nothing comes out of an empty pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(!s_axis_tvalid, 3) && $past(!s_axis_tvalid, 2) && $past(!s_axis_tvalid, 1)
      && $past(!m_axis_tvalid, 1)) |-> !m_axis_tvalid)
    else $error("result beat without input beat");

endmodule

bind aabb_affine_transform_top aat_checker u_aat_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

>>> sim/tb.sv
`default_nettype none
module tb;
  import aat_pkg::*;

  localparam int             FIELDS      = 2 * NUM_AXES;
  localparam int             CYCLE_LIMIT = 200000;
  localparam int             HOLD_CYCLES = 300;
  localparam longint         COORD_TOP   = 64'sd2147483647;
  localparam longint         COORD_BOT   = -64'sd2147483648;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_idx;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   s_valid;
  logic [BOX_W-1:0]       s_data;
  logic                   m_ready;
  logic                   s_axis_tready;
  logic                   m_axis_tvalid;
  logic [BOX_W-1:0]       m_axis_tdata;

  // predictor copy of the registers
  logic [ROW_W-1:0]       row_coefs [NUM_AXES];
  longint                 offsets   [NUM_AXES];

  logic [BOX_W-1:0]       expected_boxes [$];
  logic [BOX_W-1:0]       want;
  int                     boxes_sent;
  int                     boxes_seen;
  int                     mismatches;
  int                     settings_applied;
  int                     cycles;
  bit                     src_idle_on;
  bit                     sink_stall_on;
  bit                     hold_req;
  int                     hold_left;
  string                  field_names [FIELDS] =
    '{"new_lo_x", "new_lo_y", "new_lo_z", "new_hi_x", "new_hi_y", "new_hi_z"};

  aabb_affine_transform_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_boxes.size());
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint add_clamped(input longint acc, input longint coef,
                                         input longint v);
    longint s;
    s = acc + ((coef * v) >>> COEF_FRAC);
    if (s > COORD_TOP) begin
      s = COORD_TOP;
    end else if (s < COORD_BOT) begin
      s = COORD_BOT;
    end
    return s;
  endfunction

  function automatic logic [BOX_W-1:0] transform_box(input logic [BOX_W-1:0] box);
    logic [BOX_W-1:0] res;
    longint           lo_acc;
    longint           hi_acc;
    longint           c;
    longint           lo_v;
    longint           hi_v;
    res = '0;
    for (int r = 0; r < NUM_AXES; r++) begin
      lo_acc = offsets[r];
      hi_acc = offsets[r];
      for (int j = 0; j < NUM_AXES; j++) begin
        c    = longint'(coef_t'(row_coefs[r][j*COEF_W +: COEF_W]));
        lo_v = longint'(coord_t'(box[j*COORD_W +: COORD_W]));
        hi_v = longint'(coord_t'(box[(j+NUM_AXES)*COORD_W +: COORD_W]));
        if (c > 0) begin
          lo_acc = add_clamped(lo_acc, c, lo_v);
          hi_acc = add_clamped(hi_acc, c, hi_v);
        end else begin
          lo_acc = add_clamped(lo_acc, c, hi_v);
          hi_acc = add_clamped(hi_acc, c, lo_v);
        end
      end
      res[r*COORD_W +: COORD_W]            = COORD_W'(lo_acc);
      res[(r+NUM_AXES)*COORD_W +: COORD_W] = COORD_W'(hi_acc);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    case (idx)
      CFG_ROW_X, CFG_ROW_Y, CFG_ROW_Z: row_coefs[idx] = data;
      CFG_OFF_X, CFG_OFF_Y, CFG_OFF_Z:
        offsets[idx - CFG_OFF_X] = longint'(coord_t'(data[COORD_W-1:0]));
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic send_box(input logic [BOX_W-1:0] box);
    @(negedge clk_i);
    if (src_idle_on) begin
      while ($urandom_range(99) < 16) begin
        s_valid <= 1'b0;
        @(negedge clk_i);
      end
    end
    s_valid <= 1'b1;
    s_data  <= box;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_boxes.push_back(transform_box(box));
    boxes_sent++;
  endtask

  // drop valid and let the pipeline drain before touching the registers
  task automatic drain;
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (expected_boxes.size() != 0) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= !(sink_stall_on && $urandom_range(99) < 16);
    end
  end

  // ---------------------------------------------------------------- checker

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_ready) begin
      boxes_seen++;
      if (expected_boxes.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected result beat %h", m_axis_tdata);
        end
        mismatches++;
      end else begin
        want = expected_boxes.pop_front();
        for (int k = 0; k < FIELDS; k++) begin
          if (m_axis_tdata[k*COORD_W +: COORD_W] !== want[k*COORD_W +: COORD_W]) begin
            if (mismatches < 10) begin
              $display("result %0d %s: expected %h, got %h", boxes_seen, field_names[k],
                       want[k*COORD_W +: COORD_W], m_axis_tdata[k*COORD_W +: COORD_W]);
            end
            mismatches++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus helpers

  function automatic logic [BOX_W-1:0] pack_box(input coord_t lx, input coord_t ly,
                                                input coord_t lz, input coord_t hx,
                                                input coord_t hy, input coord_t hz);
    return {hz, hy, hx, lz, ly, lx};
  endfunction

  function automatic coord_t rand_coord;
    coord_t v;
    case ($urandom_range(3))
      0: v = coord_t'($urandom_range(32'h000F_FFFF)) - 32'sh0008_0000;
      1: v = ($urandom_range(1) ? 32'h7FFF_0000 : 32'h8000_0000) + $urandom_range(16'hFFFF);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef;
    logic [COEF_W-1:0] c;
    case ($urandom_range(5))
      0: c = '0;
      1: c = COEF_ONE + COEF_W'($urandom_range(1023)) - COEF_W'(512);
      2: c = -(COEF_ONE + COEF_W'($urandom_range(1023)) - COEF_W'(512));
      3: c = COEF_W'($urandom_range(511)) - COEF_W'(256);
      default: c = COEF_W'($urandom);
    endcase
    return c;
  endfunction

  function automatic logic [BOX_W-1:0] rand_box;
    coord_t lo [NUM_AXES];
    coord_t hi [NUM_AXES];
    coord_t t;
    for (int j = 0; j < NUM_AXES; j++) begin
      lo[j] = rand_coord();
      hi[j] = rand_coord();
      // mostly proper boxes, the rest left as drawn and so possibly inverted
      if ($urandom_range(99) < 80 && lo[j] > hi[j]) begin
        t     = lo[j];
        lo[j] = hi[j];
        hi[j] = t;
      end
    end
    return pack_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endfunction

  task automatic random_settings;
    write_reg(CFG_ROW_X, {rand_coef(), rand_coef(), rand_coef()});
    write_reg(CFG_ROW_Y, {rand_coef(), rand_coef(), rand_coef()});
    write_reg(CFG_ROW_Z, {rand_coef(), rand_coef(), rand_coef()});
    write_reg(CFG_OFF_X, {16'($urandom), rand_coord()});
    write_reg(CFG_OFF_Y, {16'($urandom), rand_coord()});
    write_reg(CFG_OFF_Z, {16'($urandom), rand_coord()});
    if ($urandom_range(1)) begin
      write_reg($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI, {$urandom, 16'($urandom)});
    end
    settings_applied++;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_identity;
    send_box('0);
    send_box({FIELDS{32'h7FFF_FFFF}});
    send_box({FIELDS{32'h8000_0000}});
    send_box(pack_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    // inverted box passes straight through
    send_box(pack_box(32'h0001_0000, 32'h7FFF_FFFF, 32'h0000_0001,
                      32'hFFFF_0000, 32'h8000_0000, 32'hFFFF_FFFF));
    send_box(pack_box(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                      32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
    drain();
  endtask

  task automatic test_coef_extremes;
    // x: zero, most negative, most positive; y: one, +1 lsb, -1 lsb; z: all most negative
    write_reg(CFG_ROW_X, {16'h7FFF, 16'h8000, 16'h0000});
    write_reg(CFG_ROW_Y, {16'hFFFF, 16'h0001, COEF_ONE});
    write_reg(CFG_ROW_Z, {16'h8000, 16'h8000, 16'h8000});
    write_reg(CFG_OFF_X, {16'hFFFF, 32'h7FFF_FFFF});
    write_reg(CFG_OFF_Y, {16'h0000, 32'h8000_0000});
    write_reg(CFG_OFF_Z, {16'hA5A5, 32'h0001_0000});
    write_reg(CFG_SPARE_LO, '1);
    write_reg(CFG_SPARE_HI, '1);
    settings_applied++;
    send_box('0);
    send_box({FIELDS{32'h7FFF_FFFF}});
    send_box({FIELDS{32'h8000_0000}});
    send_box(pack_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    // small negatives round towards minus infinity
    send_box(pack_box(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_F001,
                      32'h0000_0001, 32'h0000_0FFF, 32'h0000_1000));
    send_box(pack_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    drain();
    // flip the x and y offsets to the opposite rails and set the z offset to minus one
    write_reg(CFG_OFF_X, {16'h0000, 32'h8000_0000});
    write_reg(CFG_OFF_Y, {16'hFFFF, 32'h7FFF_FFFF});
    write_reg(CFG_OFF_Z, {16'h0000, 32'hFFFF_FFFF});
    settings_applied++;
    send_box(pack_box(32'h0010_0000, 32'hFFF0_0000, 32'h0000_8000,
                      32'h0020_0000, 32'h0010_0000, 32'h0001_0000));
    send_box({FIELDS{32'h7FFF_FFFF}});
    send_box(pack_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    drain();
  endtask

  task automatic test_random_settings;
    for (int p = 0; p < 4; p++) begin
      random_settings();
      repeat (160) send_box(rand_box());
      drain();
    end
  endtask

  task automatic test_backpressure;
    random_settings();
    src_idle_on = 1'b0;
    hold_req    = 1'b1;
    repeat (60) send_box(rand_box());
    src_idle_on = 1'b1;
    drain();
  endtask

  task automatic test_full_rate;
    random_settings();
    src_idle_on   = 1'b0;
    sink_stall_on = 1'b0;
    repeat (100) send_box(rand_box());
    drain();
    src_idle_on   = 1'b1;
    sink_stall_on = 1'b1;
  endtask

  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CFG_ROW_X;
    cfg_wdata        = '0;
    s_valid          = 1'b0;
    s_data           = '0;
    m_ready          = 1'b0;
    hold_req         = 1'b0;
    hold_left        = 0;
    src_idle_on      = 1'b1;
    sink_stall_on    = 1'b1;
    boxes_sent       = 0;
    boxes_seen       = 0;
    mismatches       = 0;
    settings_applied = 1;
    cycles           = 0;
    row_coefs[0]     = ROW_W'(COEF_ONE);
    row_coefs[1]     = ROW_W'(COEF_ONE) << COEF_W;
    row_coefs[2]     = ROW_W'(COEF_ONE) << (2 * COEF_W);
    offsets          = '{0, 0, 0};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_identity();
    test_coef_extremes();
    test_random_settings();
    test_backpressure();
    test_full_rate();

    repeat (10) @(posedge clk_i);
    $display("%0d boxes sent, %0d results checked under %0d register settings", boxes_sent,
             boxes_seen, settings_applied);
    $display("covered rail offsets, zero/negative/extreme coefficients, inverted boxes, stalls");
    if (mismatches == 0 && expected_boxes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_boxes.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
sv/aat_pkg.sv
sv/aabb_affine_transform_top.sv
sv/aat_checker.sv
sim/tb.sv
